FILE: design/bbpa_pkg.sv
// Shared constants and types for the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bbpa_pkg;

    localparam int NUM_PAGES       = 4096;
    localparam int MAX_BLOCK_ORDER = 10;
    localparam int NUM_LISTS       = MAX_BLOCK_ORDER + 1;
    localparam int PAGE_W          = 12;
    localparam int ORD_W           = 4;
    localparam int LIST_W          = $clog2(NUM_LISTS);
    localparam int CNT_W           = MAX_BLOCK_ORDER + 1;
    localparam int FCNT_W          = 13;
    localparam int STAT_W          = 2;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADORD  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // One entry of the page memory: free flag and block order.
    typedef struct packed {
        logic             free;
        logic [ORD_W-1:0] ord;
    } t_pinfo;

    // One entry of the link memory.
    typedef struct packed {
        logic [PAGE_W-1:0] nxt;
        logic [PAGE_W-1:0] prv;
    } t_link;

endpackage
`default_nettype wire

FILE: design/bbpa_ram.sv
// Simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module bbpa_ram #(
    parameter int DW = 8,
    parameter int AW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [0:(1<<AW)-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/binary_buddy_page_allocator.sv
// Top level of the binary buddy page allocator: request sequencer and list state.
//
//  Channel | Direction | Handshake                  | Word
//  request | in        | i_in_valid / o_in_ready    | i_op, i_order, i_page
//  result  | out       | o_out_valid / i_out_ready  | o_status, o_block_page,
//          |           |                            | o_free_pages_left
//
// One request is handled at a time. A refused order, an allocate that finds no
// block and a free that fails the bounds or alignment check go straight to the
// result. An allocate unlinks the head block, splits it step by step and then
// marks each page of the returned block as used. A free checks each page of the
// block, marks each page free, merges with its buddy step by step and ends with
// a final buddy check and push. After reset a clearing pass over all 4096 page
// memory entries zeroes the page memory; no request is taken during it. A
// stalled result waits in the output register and holds the sequencer in its
// last state.
`timescale 1ns / 1ps
`default_nettype none
module binary_buddy_page_allocator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_op,
    input  wire logic [bbpa_pkg::ORD_W-1:0]        i_order,
    input  wire logic [bbpa_pkg::PAGE_W-1:0]       i_page,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [bbpa_pkg::STAT_W-1:0]       o_status,
    output logic      [bbpa_pkg::PAGE_W-1:0]       o_block_page,
    output logic      [bbpa_pkg::FCNT_W-1:0]       o_free_pages_left
);

    localparam int PW  = bbpa_pkg::PAGE_W;
    localparam int OW  = bbpa_pkg::ORD_W;
    localparam int LW  = bbpa_pkg::LIST_W;
    localparam int CW  = bbpa_pkg::CNT_W;
    localparam int FW  = bbpa_pkg::FCNT_W;
    localparam int NL  = bbpa_pkg::NUM_LISTS;
    localparam int WW  = PW + CW + 1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE,
        S_UL, S_UL_D, S_UL_A, S_UL_B,
        S_PU, S_PU_A, S_PU_B,
        S_SPLIT, S_SPLIT_ADV, S_CLR_RD, S_CLR_WR,
        S_CHK_RD, S_CHK_D, S_SET_RD, S_SET_WR,
        S_MG, S_MG_D, S_MG_NX, S_MG_END,
        S_DONE
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;
    logic [OW-1:0]     r_order, n_order, r_j, n_j;
    logic [PW-1:0]     r_page, n_page, r_p, n_p, r_up, n_up, r_b, n_b;
    logic [PW-1:0]     r_nx, n_nx, r_pv, n_pv;
    logic [LW-1:0]     r_uo, n_uo;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [PW-1:0]     r_head [NL];
    logic [PW-1:0]     n_head [NL];
    logic [PW-1:0]     r_tail [NL];
    logic [PW-1:0]     n_tail [NL];
    logic [NL-1:0]     r_lvalid, n_lvalid;
    logic [FW-1:0]     r_fcnt, n_fcnt;
    logic [bbpa_pkg::STAT_W-1:0] r_res_st, n_res_st, r_o_st, n_o_st;
    logic [PW-1:0]     r_res_pg, n_res_pg, r_o_pg, n_o_pg;
    logic [FW-1:0]     r_o_fpl, n_o_fpl;
    logic              r_ovalid, n_ovalid;
    logic [PW-1:0]     r_init, n_init;

    // Memory ports.
    logic              fo_we, fo_re, lk_we, lk_re;
    logic [PW-1:0]     fo_waddr, fo_raddr, lk_waddr, lk_raddr;
    bbpa_pkg::t_pinfo  fo_wdata, fo_q;
    bbpa_pkg::t_link   lk_wdata, lk_q;

    bbpa_ram #(.DW(OW + 1), .AW(PW)) u_page_mem (
        .i_clk   (i_clk),
        .i_we    (fo_we),
        .i_waddr (fo_waddr),
        .i_wdata (fo_wdata),
        .i_re    (fo_re),
        .i_raddr (fo_raddr),
        .o_rdata (fo_q)
    );

    bbpa_ram #(.DW(2 * PW), .AW(PW)) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (lk_re),
        .i_raddr (lk_raddr),
        .o_rdata (lk_q)
    );

    logic [CW-1:0] w_size;
    logic [WW-1:0] w_m, w_bud;
    logic          w_found;
    logic [OW-1:0] w_jsel;
    logic          w_ok;

    assign w_size = CW'(1) << r_order;
    assign w_m    = WW'(1) << r_j;
    assign w_bud  = ((WW'(r_p) & w_m) != '0) ? (WW'(r_p) - w_m) : (WW'(r_p) + w_m);

    // First non-empty list at or above the requested order.
    always_comb begin
        w_found = 1'b0;
        w_jsel  = '0;
        for (int k = 0; k < NL; k++) begin
            if (!w_found && (OW'(k) >= i_order) && r_lvalid[k]) begin
                w_found = 1'b1;
                w_jsel  = OW'(k);
            end
        end
    end

    // Bounds and alignment check of a free request.
    always_comb begin
        logic [WW-1:0] sz;
        sz   = WW'(1) << i_order;
        w_ok = ((WW'(i_page) + sz) <= WW'(bbpa_pkg::NUM_PAGES))
            && ((WW'(i_page) & (sz - WW'(1))) == '0);
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer next state.
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_order  = r_order;
        n_j      = r_j;
        n_page   = r_page;
        n_p      = r_p;
        n_up     = r_up;
        n_uo     = r_uo;
        n_b      = r_b;
        n_nx     = r_nx;
        n_pv     = r_pv;
        n_cnt    = r_cnt;
        n_head   = r_head;
        n_tail   = r_tail;
        n_lvalid = r_lvalid;
        n_fcnt   = r_fcnt;
        n_res_st = r_res_st;
        n_res_pg = r_res_pg;
        n_o_st   = r_o_st;
        n_o_pg   = r_o_pg;
        n_o_fpl  = r_o_fpl;
        n_ovalid = r_ovalid;
        n_init   = r_init;
        fo_we    = 1'b0;
        fo_waddr = '0;
        fo_wdata = '0;
        fo_re    = 1'b0;
        fo_raddr = '0;
        lk_we    = 1'b0;
        lk_waddr = '0;
        lk_wdata = '0;
        lk_re    = 1'b0;
        lk_raddr = '0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            // Clearing pass over the page memory.
            S_INIT: begin
                fo_we    = 1'b1;
                fo_waddr = r_init;
                n_init   = r_init + PW'(1);
                if (r_init == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_order  = i_order;
                    n_page   = i_page;
                    n_res_st = bbpa_pkg::ST_DONE;
                    n_res_pg = '0;
                    n_cnt    = '0;
                    if (i_order > OW'(bbpa_pkg::MAX_BLOCK_ORDER)) begin
                        n_res_st = bbpa_pkg::ST_BADORD;
                        n_state  = S_DONE;
                    end else if (i_op == bbpa_pkg::OP_ALLOC) begin
                        if (!w_found) begin
                            n_res_st = bbpa_pkg::ST_NOSPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_j     = w_jsel;
                            n_p     = r_head[w_jsel[LW-1:0]];
                            n_up    = r_head[w_jsel[LW-1:0]];
                            n_uo    = w_jsel[LW-1:0];
                            n_ret   = S_SPLIT;
                            n_state = S_UL;
                        end
                    end else if (w_ok) begin
                        n_state = S_CHK_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            // Unlink r_up from list r_uo.
            S_UL: begin
                if ((r_head[r_uo] == r_up) && (r_tail[r_uo] == r_up)) begin
                    n_lvalid[r_uo] = 1'b0;
                    n_state        = r_ret;
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = r_up;
                    n_state  = S_UL_D;
                end
            end
            S_UL_D: begin
                n_nx = lk_q.nxt;
                n_pv = lk_q.prv;
                if (r_head[r_uo] == r_up) begin
                    n_head[r_uo] = lk_q.nxt;
                    n_state      = r_ret;
                end else if (r_tail[r_uo] == r_up) begin
                    n_tail[r_uo] = lk_q.prv;
                    n_state      = r_ret;
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = lk_q.prv;
                    n_state  = S_UL_A;
                end
            end
            S_UL_A: begin
                lk_we    = 1'b1;
                lk_waddr = r_pv;
                lk_wdata = '{nxt: r_nx, prv: lk_q.prv};
                lk_re    = 1'b1;
                lk_raddr = r_nx;
                n_state  = S_UL_B;
            end
            S_UL_B: begin
                lk_we    = 1'b1;
                lk_waddr = r_nx;
                lk_wdata = '{nxt: lk_q.nxt, prv: r_pv};
                n_state  = r_ret;
            end
            // Push r_up to the tail of list r_uo.
            S_PU: begin
                if (!r_lvalid[r_uo]) begin
                    n_lvalid[r_uo] = 1'b1;
                    n_head[r_uo]   = r_up;
                    n_tail[r_uo]   = r_up;
                    n_state        = r_ret;
                end else begin
                    lk_re    = 1'b1;
                    lk_raddr = r_tail[r_uo];
                    n_state  = S_PU_A;
                end
            end
            S_PU_A: begin
                lk_we    = 1'b1;
                lk_waddr = r_tail[r_uo];
                lk_wdata = '{nxt: r_up, prv: lk_q.prv};
                n_state  = S_PU_B;
            end
            S_PU_B: begin
                lk_we        = 1'b1;
                lk_waddr     = r_up;
                lk_wdata     = '{nxt: '0, prv: r_tail[r_uo]};
                n_tail[r_uo] = r_up;
                n_state      = r_ret;
            end
            // Allocate: split off lower halves until the order fits.
            S_SPLIT: begin
                if (r_j == r_order) begin
                    n_cnt   = '0;
                    n_state = S_CLR_RD;
                end else begin
                    n_j      = r_j - OW'(1);
                    fo_we    = 1'b1;
                    fo_waddr = r_p;
                    fo_wdata = '{free: 1'b1, ord: r_j - OW'(1)};
                    n_up     = r_p;
                    n_uo     = LW'(r_j - OW'(1));
                    n_ret    = S_SPLIT_ADV;
                    n_state  = S_PU;
                end
            end
            S_SPLIT_ADV: begin
                n_p     = r_p + (PW'(1) << r_j);
                n_state = S_SPLIT;
            end
            S_CLR_RD: begin
                fo_re    = 1'b1;
                fo_raddr = r_p + PW'(r_cnt);
                n_state  = S_CLR_WR;
            end
            S_CLR_WR: begin
                fo_we    = 1'b1;
                fo_waddr = r_p + PW'(r_cnt);
                fo_wdata = '{free: 1'b0, ord: fo_q.ord};
                n_cnt    = r_cnt + CW'(1);
                if ((r_cnt + CW'(1)) == w_size) begin
                    n_fcnt   = r_fcnt - FW'(w_size);
                    n_res_pg = r_p;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_CLR_RD;
                end
            end
            // Free: refuse if any page of the block is already free.
            S_CHK_RD: begin
                fo_re    = 1'b1;
                fo_raddr = r_page + PW'(r_cnt);
                n_state  = S_CHK_D;
            end
            S_CHK_D: begin
                if (fo_q.free) begin
                    n_state = S_DONE;
                end else if ((r_cnt + CW'(1)) == w_size) begin
                    n_cnt   = '0;
                    n_state = S_SET_RD;
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_CHK_RD;
                end
            end
            S_SET_RD: begin
                fo_re    = 1'b1;
                fo_raddr = r_page + PW'(r_cnt);
                n_state  = S_SET_WR;
            end
            S_SET_WR: begin
                fo_we    = 1'b1;
                fo_waddr = r_page + PW'(r_cnt);
                fo_wdata = '{free: 1'b1, ord: fo_q.ord};
                n_cnt    = r_cnt + CW'(1);
                if ((r_cnt + CW'(1)) == w_size) begin
                    n_fcnt  = r_fcnt + FW'(w_size);
                    n_p     = r_page;
                    n_j     = r_order;
                    n_state = S_MG;
                end else begin
                    n_state = S_SET_RD;
                end
            end
            // Merge with the aligned buddy while it is free and of equal order.
            S_MG: begin
                if (r_j >= OW'(bbpa_pkg::MAX_BLOCK_ORDER)) begin
                    n_state = S_MG_END;
                end else if (w_bud >= WW'(bbpa_pkg::NUM_PAGES)) begin
                    n_state = S_MG_END;
                end else begin
                    fo_re    = 1'b1;
                    fo_raddr = w_bud[PW-1:0];
                    n_b      = w_bud[PW-1:0];
                    n_state  = S_MG_D;
                end
            end
            S_MG_D: begin
                if (!fo_q.free || (fo_q.ord != r_j)) begin
                    n_state = S_MG_END;
                end else begin
                    n_up    = r_b;
                    n_uo    = LW'(r_j);
                    n_ret   = S_MG_NX;
                    n_state = S_UL;
                end
            end
            S_MG_NX: begin
                if ((WW'(r_p) & w_m) != '0) begin
                    n_p = r_b;
                end
                n_j     = r_j + OW'(1);
                n_state = S_MG;
            end
            S_MG_END: begin
                fo_we    = 1'b1;
                fo_waddr = r_p;
                fo_wdata = '{free: 1'b1, ord: r_j};
                n_up     = r_p;
                n_uo     = LW'(r_j);
                n_ret    = S_DONE;
                n_state  = S_PU;
            end
            // Hand the result word to the output register.
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_o_st   = r_res_st;
                    n_o_pg   = r_res_pg;
                    n_o_fpl  = r_fcnt;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ret    <= S_IDLE;
            r_lvalid <= '0;
            r_fcnt   <= '0;
            r_ovalid <= 1'b0;
            r_init   <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_lvalid <= n_lvalid;
            r_fcnt   <= n_fcnt;
            r_ovalid <= n_ovalid;
            r_init   <= n_init;
            r_cnt    <= n_cnt;
        end
        r_order  <= n_order;
        r_j      <= n_j;
        r_page   <= n_page;
        r_p      <= n_p;
        r_up     <= n_up;
        r_uo     <= n_uo;
        r_b      <= n_b;
        r_nx     <= n_nx;
        r_pv     <= n_pv;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_res_st <= n_res_st;
        r_res_pg <= n_res_pg;
        r_o_st   <= n_o_st;
        r_o_pg   <= n_o_pg;
        r_o_fpl  <= n_o_fpl;
    end

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_o_st;
    assign o_block_page      = r_o_pg;
    assign o_free_pages_left = r_o_fpl;

endmodule
`default_nettype wire
